FILE: rtl/cfbl_pkg.sv
// Shared types and constants for the command frame builder with LRC checksums.
// Used by the front classifier, the job queue and the byte sequencer.
package cfbl_pkg;

   // Operation codes carried on the input selector.
   localparam logic OP_START = 1'b0;
   localparam logic OP_DATA  = 1'b1;

   // Frame magic bytes.
   localparam logic [7:0] MAGIC_HI = 8'h11;
   localparam logic [7:0] MAGIC_LO = 8'hEF;

   // Modulus of the LRC arithmetic (two's-complement negation mod 256).
   localparam logic [8:0] LRC_MOD = 9'h100;

   typedef enum logic [1:0] {
      JOB_HEADER,
      JOB_DATA,
      JOB_STRAY
   } job_kind_type;

   // One classified item, ready for the sequencer.
   typedef struct packed {
      job_kind_type kind;
      logic [15:0]  command;
      logic [15:0]  frame_length;
      logic [7:0]   data_byte;
      logic         close;   // the data LRC follows this job's bytes
      logic [7:0]   check;   // header LRC for a header, data LRC for a closing data item
   } job_type;

   function automatic logic [7:0] lrc_of(input logic [7:0] sum);
      logic [8:0] diff;
      diff = LRC_MOD - {1'b0, sum};
      return diff[7:0];
   endfunction

endpackage

FILE: rtl/command_frame_builder_lrc_core.sv
// Command frame builder with LRC checksums. A start item (req_tuser = 0) gives
// the nine-byte header 11 EF, command, two zero status bytes, length and header
// LRC, plus the data LRC at once when the length is zero; each data item
// (req_tuser = 1) gives its byte and, after the last payload byte, the data LRC
// with rsp_tlast set. A data item with no frame open gives one byte 00 with
// rsp_tuser set. Items are accepted one per cycle while the QUEUE_DEPTH-entry
// job queue has room; the output side emits one byte per cycle while rsp_tready
// allows, so a payload item gives one byte (two when it closes the frame) and a
// start nine or ten. That single output byte per cycle sets the sustained rate.
module command_frame_builder_lrc_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // command[15:0], frame_length[31:16], data_byte[39:32]
   input  logic        req_tuser,   // operation[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte[7:0]
   output logic        rsp_tlast,
   output logic        rsp_tuser    // stray_data[0]
);
   import cfbl_pkg::*;

   logic    push;
   logic    pop;
   logic    queue_full;
   logic    head_valid;
   job_type push_job;
   job_type head_job;

   cfbl_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .queue_full   (queue_full),
      .operation    (req_tuser),
      .command      (req_tdata[15:0]),
      .frame_length (req_tdata[31:16]),
      .data_byte    (req_tdata[39:32]),
      .in_ready     (req_tready),
      .push         (push),
      .job          (push_job)
   );

   cfbl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   cfbl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_byte   (rsp_tdata),
      .frame_end  (rsp_tlast),
      .stray_data (rsp_tuser)
   );

endmodule

FILE: rtl/cfbl_front.sv
// Front end of the command frame builder: accepts items, tracks the open frame
// and turns each item into a job for the sequencer. Depends on cfbl_pkg.
module cfbl_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic             queue_full,
   input  logic             operation,
   input  logic [15:0]      command,
   input  logic [15:0]      frame_length,
   input  logic [7:0]       data_byte,
   output logic             in_ready,
   output logic             push,
   output cfbl_pkg::job_type job
);
   import cfbl_pkg::*;

   logic        frame_open_ff, frame_open_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [7:0]  payload_sum_ff, payload_sum_in;
   logic [7:0]  sum_plus;
   logic [7:0]  hdr_sum;

   assign in_ready = !queue_full;
   assign push     = in_valid && in_ready;

   assign sum_plus = payload_sum_ff + data_byte;
   assign hdr_sum  = command[15:8] + command[7:0] + frame_length[15:8] + frame_length[7:0];

   always_comb begin
      job.command      = command;
      job.frame_length = frame_length;
      job.data_byte    = data_byte;
      job.kind         = JOB_STRAY;
      job.close        = 1'b0;
      job.check        = 8'h00;
      frame_open_in    = frame_open_ff;
      bytes_left_in    = bytes_left_ff;
      payload_sum_in   = payload_sum_ff;
      if (operation == OP_START) begin
         job.kind       = JOB_HEADER;
         job.close      = (frame_length == 16'd0);
         job.check      = lrc_of(hdr_sum);
         frame_open_in  = (frame_length != 16'd0);
         bytes_left_in  = frame_length;
         payload_sum_in = 8'h00;
      end else if (frame_open_ff) begin
         job.kind      = JOB_DATA;
         job.close     = (bytes_left_ff == 16'd1);
         job.check     = lrc_of(sum_plus);
         bytes_left_in = bytes_left_ff - 16'd1;
         if (bytes_left_ff == 16'd1) begin
            frame_open_in  = 1'b0;
            payload_sum_in = 8'h00;
         end else begin
            payload_sum_in = sum_plus;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff  <= 1'b0;
         bytes_left_ff  <= 16'd0;
         payload_sum_ff <= 8'h00;
      end else if (push) begin
         frame_open_ff  <= frame_open_in;
         bytes_left_ff  <= bytes_left_in;
         payload_sum_ff <= payload_sum_in;
      end
   end

`ifndef SYNTHESIS
   a_open_matches_count: assert property (@(posedge clock) disable iff (reset)
      frame_open_ff == (bytes_left_ff != 16'd0))
      else $error("frame open flag disagrees with remaining byte count");

   a_sum_clear_when_closed: assert property (@(posedge clock) disable iff (reset)
      !frame_open_ff |-> (payload_sum_ff == 8'h00))
      else $error("payload sum not cleared while no frame is open");
`endif

endmodule

FILE: rtl/cfbl_queue.sv
// Short job queue between the front end and the byte sequencer.
// Holds cfbl_pkg::job_type entries in first-in, first-out order.
module cfbl_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cfbl_pkg::job_type push_job,
   input  logic              pop,
   output logic              full,
   output logic              head_valid,
   output cfbl_pkg::job_type head_job
);
   import cfbl_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type              entries_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("job queue written while full");
`endif

endmodule

FILE: rtl/cfbl_back.sv
// Byte sequencer of the command frame builder (depends on cfbl_pkg): walks the
// queue head job, one byte per cycle unless stalled, into a registered output.
module cfbl_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  cfbl_pkg::job_type head_job,
   output logic              pop,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [7:0]        out_byte,
   output logic              frame_end,
   output logic              stray_data
);
   import cfbl_pkg::*;

   localparam logic [3:0] STEP_MAGIC_HI = 4'd0;
   localparam logic [3:0] STEP_MAGIC_LO = 4'd1;
   localparam logic [3:0] STEP_CMD_HI   = 4'd2;
   localparam logic [3:0] STEP_CMD_LO   = 4'd3;
   localparam logic [3:0] STEP_STAT_HI  = 4'd4;
   localparam logic [3:0] STEP_STAT_LO  = 4'd5;
   localparam logic [3:0] STEP_LEN_HI   = 4'd6;
   localparam logic [3:0] STEP_LEN_LO   = 4'd7;
   localparam logic [3:0] STEP_HDR_LRC  = 4'd8;
   localparam logic [3:0] STEP_DATA_LRC = 4'd9;

   logic [3:0] step_ff, step_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff;
   logic       frame_end_ff;
   logic       stray_data_ff;
   logic       advance;
   logic       emit;
   logic       last;
   logic [7:0] byte_sel;
   logic       end_sel;

   assign advance = !out_valid_ff || out_ready;
   assign emit    = advance && head_valid;

   always_comb begin
      byte_sel = 8'h00;
      end_sel  = 1'b0;
      last     = 1'b1;
      case (head_job.kind)
         JOB_HEADER: begin
            case (step_ff)
               STEP_MAGIC_HI: byte_sel = MAGIC_HI;
               STEP_MAGIC_LO: byte_sel = MAGIC_LO;
               STEP_CMD_HI:   byte_sel = head_job.command[15:8];
               STEP_CMD_LO:   byte_sel = head_job.command[7:0];
               STEP_STAT_HI:  byte_sel = 8'h00;
               STEP_STAT_LO:  byte_sel = 8'h00;
               STEP_LEN_HI:   byte_sel = head_job.frame_length[15:8];
               STEP_LEN_LO:   byte_sel = head_job.frame_length[7:0];
               STEP_HDR_LRC:  byte_sel = head_job.check;
               STEP_DATA_LRC: begin
                  // An empty payload sums to zero, so its LRC is zero.
                  byte_sel = lrc_of(8'h00);
                  end_sel  = 1'b1;
               end
               default:       byte_sel = 8'h00;
            endcase
            last = (step_ff == STEP_DATA_LRC) ||
                   (step_ff == STEP_HDR_LRC && !head_job.close);
         end
         JOB_DATA: begin
            if (step_ff == STEP_MAGIC_HI) begin
               byte_sel = head_job.data_byte;
               last     = !head_job.close;
            end else begin
               byte_sel = head_job.check;
               end_sel  = 1'b1;
            end
         end
         JOB_STRAY: begin
            byte_sel = 8'h00;
         end
         default: begin
            byte_sel = 8'h00;
         end
      endcase
   end

   assign pop = emit && last;

   always_comb begin
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      if (emit) begin
         step_in      = last ? STEP_MAGIC_HI : step_ff + 4'd1;
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_MAGIC_HI;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_byte_ff   <= byte_sel;
         frame_end_ff  <= end_sel;
         stray_data_ff <= (head_job.kind == JOB_STRAY);
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_byte   = out_byte_ff;
   assign frame_end  = frame_end_ff;
   assign stray_data = stray_data_ff;

`ifndef SYNTHESIS
   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_DATA_LRC)
      else $error("sequencer step beyond the data LRC");

   a_step_needs_job: assert property (@(posedge clock) disable iff (reset)
      (step_ff != STEP_MAGIC_HI) |-> head_valid)
      else $error("sequencer mid-job with an empty queue");
`endif

endmodule

FILE: sim/command_frame_builder_lrc_core_tb.sv
// Self-checking testbench for command_frame_builder_lrc_core.
// Depends on rtl/cfbl_pkg.sv and the rest of the RTL under rtl/.
// A predictor tracks the frame state and every output byte is checked in order.
module command_frame_builder_lrc_core_tb;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 300;
   localparam int RANDOM_ITEMS = 170;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
      logic       stray_data;
   } frame_byte_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;    // command[15:0], frame_length[31:16], data_byte[39:32]
   logic        req_tuser;    // operation[0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;    // out_byte[7:0]
   logic        rsp_tlast;
   logic        rsp_tuser;    // stray_data[0]

   // Predictor state, updated as each item is accepted.
   frame_byte_type expected_bytes[$];
   logic [7:0]  model_sum;
   logic [15:0] model_left;
   logic        model_open;

   int  fail_count;
   int  cycle_count;
   int  items_sent;

   // Sender and receiver pacing.
   bit  sender_gaps;
   int  burst_left;
   int  hold_asked;
   int  hold_served;
   int  hold_left;
   int  stall_pct;
   int  phase_left;

   command_frame_builder_lrc_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void expect_byte(logic [7:0] b, logic e, logic s);
      frame_byte_type entry;
      entry.out_byte   = b;
      entry.frame_end  = e;
      entry.stray_data = s;
      expected_bytes.insert(expected_bytes.size(), entry);
   endfunction

   function automatic void predict_frame_bytes(logic op, logic [15:0] cmd, logic [15:0] len,
                                               logic [7:0] db);
      logic [7:0] hdr [6];
      logic [7:0] hdr_sum;
      hdr_sum = 8'h00;
      if (op == cfbl_pkg::OP_START) begin
         hdr = '{cmd[15:8], cmd[7:0], 8'h00, 8'h00, len[15:8], len[7:0]};
         expect_byte(cfbl_pkg::MAGIC_HI, 1'b0, 1'b0);
         expect_byte(cfbl_pkg::MAGIC_LO, 1'b0, 1'b0);
         foreach (hdr[i]) begin
            hdr_sum = hdr_sum + hdr[i];
            expect_byte(hdr[i], 1'b0, 1'b0);
         end
         expect_byte(8'h00 - hdr_sum, 1'b0, 1'b0);
         model_sum = 8'h00;
         if (len == 16'd0) begin
            // An empty payload closes the frame at once with a zero check byte.
            expect_byte(8'h00, 1'b1, 1'b0);
            model_left = 16'd0;
            model_open = 1'b0;
         end else begin
            model_left = len;
            model_open = 1'b1;
         end
      end else if (!model_open) begin
         expect_byte(8'h00, 1'b0, 1'b1);
      end else begin
         model_sum  = model_sum + db;
         model_left = model_left - 16'd1;
         expect_byte(db, 1'b0, 1'b0);
         if (model_left == 16'd0) begin
            expect_byte(8'h00 - model_sum, 1'b1, 1'b0);
            model_open = 1'b0;
            model_sum  = 8'h00;
         end
      end
   endfunction

   // Prediction and checking share one edge-sampled process so that an item and
   // a result accepted at the same edge are handled in a fixed order.
   always @(posedge clock) begin : monitor_blk
      frame_byte_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("command_frame_builder_lrc_core verification failed");
         $finish;
      end
      if (reset) begin
         model_sum  = 8'h00;
         model_left = 16'd0;
         model_open = 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            predict_frame_bytes(req_tuser, req_tdata[15:0], req_tdata[31:16], req_tdata[39:32]);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               $error("unexpected result: out_byte %02h frame_end %0b stray_data %0b",
                      rsp_tdata, rsp_tlast, rsp_tuser);
               fail_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_tdata !== want.out_byte) begin
                  $error("out_byte: expected %02h, actual %02h", want.out_byte, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tlast !== want.frame_end) begin
                  $error("frame_end: expected %0b, actual %0b", want.frame_end, rsp_tlast);
                  fail_count++;
               end
               if (rsp_tuser !== want.stray_data) begin
                  $error("stray_data: expected %0b, actual %0b", want.stray_data, rsp_tuser);
                  fail_count++;
               end
            end
         end
      end
   end

   // The receiver alternates between calm and stall-heavy phases, and takes a
   // long hold-off whenever a test asks for one.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_served != hold_asked) begin
         hold_served++;
         hold_left   = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(20, 120);
            stall_pct  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 70);
         end
         phase_left--;
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task automatic send_item(logic op, logic [15:0] cmd, logic [15:0] len, logic [7:0] db);
      if (sender_gaps && burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left > 0)
         burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {db, len, cmd};
      do
         @(posedge clock);
      while (!req_tready);
      items_sent++;
   endtask

   // Start items carry a random data byte and data items random header fields,
   // so that the unused fields toggle too.
   task automatic send_start(logic [15:0] cmd, logic [15:0] len);
      send_item(cfbl_pkg::OP_START, cmd, len, 8'($urandom));
   endtask

   task automatic send_data(logic [7:0] db);
      send_item(cfbl_pkg::OP_DATA, 16'($urandom), 16'($urandom), db);
   endtask

   task automatic test_corner_frames();
      send_data(8'hFF);                 // nothing open after reset
      send_start(16'h0000, 16'h0000);
      send_start(16'hFFFF, 16'h0000);
      send_data(8'h00);                 // stray after a closed frame
      send_start(16'h1234, 16'h0003);
      send_data(8'hFF);
      send_data(8'h00);
      send_data(8'h80);
      send_start(16'hA55A, 16'h0001);
      send_data(8'h00);                 // zero payload sum
      send_start(16'h00FF, 16'h0002);
      send_data(8'h01);
      send_data(8'hFF);                 // sum wraps to zero
   endtask

   task automatic test_abandoned_frames();
      send_start(16'hABCD, 16'hFFFF);
      send_data(8'h55);
      send_data(8'hAA);
      send_start(16'hFF00, 16'h0100);   // abandons the open frame
      send_data(8'h7F);
      send_start(16'h8001, 16'h0002);
      send_data(8'hC3);
      send_data(8'h3C);
      send_data(8'h99);                 // frame already closed
   endtask

   // The receiver stops for a long stretch while the sender keeps offering items
   // back to back, so the block fills and holds its input.
   task automatic test_output_backpressure();
      sender_gaps = 1'b0;
      hold_asked++;
      send_start(16'h5AA5, 16'd24);
      repeat (24) send_data(8'($urandom));
      send_start(16'h0F0F, 16'd0);
      send_data(8'($urandom));
      sender_gaps = 1'b1;
   endtask

   task automatic test_random_frames();
      int target;
      int len;
      int count;
      int choice;
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         choice = $urandom_range(0, 99);
         sender_gaps = ($urandom_range(0, 3) != 0);
         if (choice < 8) begin
            send_data(8'($urandom));
         end else if (choice < 18) begin
            // Any length at all, cut short by the next start.
            send_start(16'($urandom), 16'($urandom));
            repeat ($urandom_range(0, 4)) send_data(8'($urandom));
         end else begin
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            count = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : len;
            send_start(16'($urandom), 16'(len));
            repeat (count) send_data(8'($urandom));
         end
      end
      sender_gaps = 1'b1;
   endtask

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = 1'b0;
      items_sent   = 0;
      sender_gaps  = 1'b1;
      burst_left   = 0;
      hold_asked   = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corner_frames();
      test_abandoned_frames();
      test_output_backpressure();
      test_random_frames();

      req_tvalid <= 1'b0;
      while (expected_bytes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("command_frame_builder_lrc_core verification clean");
      else
         $display("command_frame_builder_lrc_core verification failed");
      $finish;
   end

endmodule
